// ===== rtl/core/pwfs_pkg.sv =====
// Shared types, constants and a helper function of the pulse width frame serializer.
package pwfs_pkg;

	localparam int TimeW    = 16;
	localparam int CfgAddrW = 2;
	localparam int ModeW    = 2;
	localparam int CodeW    = 2;
	localparam int DataW    = 8;

	typedef logic [TimeW-1:0] ticks_t;

	typedef enum logic [CfgAddrW-1:0] {
		REG_LONG_PULSE  = 2'd0,
		REG_SHORT_PULSE = 2'd1,
		REG_GAP         = 2'd2
	} cfg_reg_t;

	localparam logic KIND_REQUEST = 1'b0;
	localparam logic KIND_TICK    = 1'b1;

	localparam ticks_t LONG_PULSE_RST  = 16'd50;
	localparam ticks_t SHORT_PULSE_RST = 16'd1;
	localparam ticks_t GAP_RST         = 16'd10;

	typedef struct packed {
		ticks_t long_pulse;
		ticks_t short_pulse;
		ticks_t gap;
	} timing_t;

	typedef struct packed {
		logic             kind;
		logic [ModeW-1:0] mode_bits;
		logic [CodeW-1:0] param_code;
		logic [DataW-1:0] data_byte;
	} req_item_t;

	typedef struct packed {
		logic pin_level;
		logic busy_res;
		logic accepted;
		logic frame_done;
	} res_item_t;

	// A programmed duration of zero counts as one tick.
	function automatic ticks_t at_least_one(input ticks_t v);
		return (v == '0) ? ticks_t'(1) : v;
	endfunction

endpackage

// ===== rtl/core/pwfs_req_if.sv =====
// Request channel: frame requests and time ticks with valid and ready.
interface pwfs_req_if import pwfs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             kind;
	logic [ModeW-1:0] mode_bits;
	logic [CodeW-1:0] param_code;
	logic [DataW-1:0] data_byte;

	modport source(output valid, kind, mode_bits, param_code, data_byte, input ready);
	modport sink(input valid, kind, mode_bits, param_code, data_byte, output ready);
endinterface

// ===== rtl/core/pwfs_res_if.sv =====
// Result channel: line level and status flags with valid and ready.
interface pwfs_res_if import pwfs_pkg::*; ();
	logic valid;
	logic ready;
	logic pin_level;
	logic busy_res;
	logic accepted;
	logic frame_done;

	modport source(output valid, pin_level, busy_res, accepted, frame_done, input ready);
	modport sink(input valid, pin_level, busy_res, accepted, frame_done, output ready);
endinterface

// ===== rtl/core/pwfs_cfg_if.sv =====
// Configuration write channel: register index and write data with valid and ready.
interface pwfs_cfg_if import pwfs_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CfgAddrW-1:0] addr;
	logic [TimeW-1:0]    data;

	modport source(output valid, addr, data, input ready);
	modport sink(input valid, addr, data, output ready);
endinterface

// ===== rtl/core/pwfs_cfg_regs.sv =====
// Timing configuration registers written through the configuration channel.
module pwfs_cfg_regs import pwfs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	pwfs_cfg_if.sink     cfg,
	output timing_t      timing
);

	timing_t timing_q;

	assign cfg.ready = 1'b1;
	assign timing    = timing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.long_pulse  <= LONG_PULSE_RST;
			timing_q.short_pulse <= SHORT_PULSE_RST;
			timing_q.gap         <= GAP_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_reg_t'(cfg.addr))
				REG_LONG_PULSE:  timing_q.long_pulse  <= cfg.data;
				REG_SHORT_PULSE: timing_q.short_pulse <= cfg.data;
				REG_GAP:         timing_q.gap         <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/core/pwfs_in_stage.sv =====
// Input register that captures one transaction from the request channel.
module pwfs_in_stage import pwfs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	pwfs_req_if.sink  req,
	input  logic      advance,
	output logic      valid_s1,
	output req_item_t item_s1
);

	logic      vld_s1;
	req_item_t itm_s1;

	assign req.ready = !vld_s1 || advance;
	assign valid_s1  = vld_s1;
	assign item_s1   = itm_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.ready) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			itm_s1.kind       <= req.kind;
			itm_s1.mode_bits  <= req.mode_bits;
			itm_s1.param_code <= req.param_code;
			itm_s1.data_byte  <= req.data_byte;
		end
	end

endmodule

// ===== rtl/core/pwfs_engine.sv =====
// Frame state, one-step waveform update and the result register.
module pwfs_engine import pwfs_pkg::*; #(
	parameter int MarkRun = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      valid_s1,
	input  req_item_t item_s1,
	input  timing_t   timing,
	input  logic      out_ready,
	output logic      advance,
	output logic      res_valid,
	output res_item_t res
);

	localparam int FrameLen = 18 + 2 * MarkRun;
	localparam int BitsW    = $clog2(FrameLen + 1);

	logic [FrameLen-1:0] shift_q, shift_n, frame;
	logic [BitsW-1:0]    bits_left_q, bits_left_n, bits_dec;
	logic                high_q, high_n;
	ticks_t              timer_q, timer_n, timer_dec;
	logic                sending_q, sending_n;
	logic                res_valid_q;
	res_item_t           res_q, res_n;

	assign advance   = !res_valid_q || out_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign frame = {1'b1, {MarkRun{1'b0}}, 1'b1, item_s1.mode_bits, item_s1.param_code,
		2'b10, item_s1.data_byte, 1'b0, {MarkRun{1'b1}}, 1'b0};

	assign timer_dec = (timer_q != '0) ? timer_q - ticks_t'(1) : '0;
	assign bits_dec  = (bits_left_q != '0) ? bits_left_q - BitsW'(1) : '0;

	always_comb begin
		shift_n     = shift_q;
		bits_left_n = bits_left_q;
		high_n      = high_q;
		timer_n     = timer_q;
		sending_n   = sending_q;
		res_n       = '0;
		if (item_s1.kind == KIND_REQUEST) begin
			if (!sending_q) begin
				shift_n        = frame;
				bits_left_n    = BitsW'(FrameLen);
				sending_n      = 1'b1;
				high_n         = 1'b1;
				timer_n        = at_least_one(frame[FrameLen-1] ? timing.long_pulse
					: timing.short_pulse);
				res_n.accepted = 1'b1;
			end
			res_n.pin_level = sending_n && high_n;
		end else if (sending_q) begin
			res_n.pin_level = high_q;
			timer_n         = timer_dec;
			if (timer_dec == '0) begin
				if (high_q) begin
					high_n  = 1'b0;
					timer_n = at_least_one(timing.gap);
				end else begin
					bits_left_n = bits_dec;
					if (bits_dec == '0) begin
						sending_n        = 1'b0;
						high_n           = 1'b0;
						res_n.frame_done = 1'b1;
					end else begin
						shift_n = {shift_q[FrameLen-2:0], 1'b0};
						high_n  = 1'b1;
						timer_n = at_least_one(shift_q[FrameLen-2] ? timing.long_pulse
							: timing.short_pulse);
					end
				end
			end
		end
		res_n.busy_res = sending_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q     <= '0;
			bits_left_q <= '0;
			high_q      <= 1'b0;
			timer_q     <= '0;
			sending_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
			if (valid_s1) begin
				shift_q     <= shift_n;
				bits_left_q <= bits_left_n;
				high_q      <= high_n;
				timer_q     <= timer_n;
				sending_q   <= sending_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q <= res_n;
		end
	end

endmodule

// ===== rtl/core/pulse_width_frame_serializer_unit.sv =====
// Top level of the pulse width one-wire frame serializer.
// Path: each transaction is held in the input register and then in the result register.
// Throughput: one transaction per cycle; the request channel stalls while the result
// channel does and both registers are full.
// Reset: asynchronous, active low; the line is idle and the timing registers take
// their default values (long pulse 50, short pulse 1, gap 10 ticks).
module pulse_width_frame_serializer_unit import pwfs_pkg::*; #(
	parameter int MARK_RUN = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	pwfs_req_if.sink    req,
	pwfs_res_if.source  res,
	pwfs_cfg_if.sink    cfg
);

	timing_t   timing;
	logic      advance;
	logic      valid_s1;
	req_item_t item_s1;
	logic      res_valid;
	res_item_t res_item;

	pwfs_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.timing (timing)
	);

	pwfs_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	pwfs_engine #(
		.MarkRun (MARK_RUN)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.timing    (timing),
		.out_ready (res.ready),
		.advance   (advance),
		.res_valid (res_valid),
		.res       (res_item)
	);

	assign res.valid      = res_valid;
	assign res.pin_level  = res_item.pin_level;
	assign res.busy_res   = res_item.busy_res;
	assign res.accepted   = res_item.accepted;
	assign res.frame_done = res_item.frame_done;

	a_accept_starts_frame: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.accepted |-> res_item.busy_res && res_item.pin_level)
		else $error("Accepted frame does not start with a high pulse.");

	a_done_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.frame_done |-> !res_item.busy_res && !res_item.pin_level)
		else $error("Frame end reported while the line is still busy.");

	a_stall_holds_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.ready |=> res_valid && $stable(res_item))
		else $error("Result register changed while the result channel stalled.");

	a_input_waits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("Input register lost a transaction during a stall.");

endmodule

// ===== dv/pulse_width_frame_serializer_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the serializer: drives requests, ticks and configuration writes and checks each result.
module pulse_width_frame_serializer_unit_tb;
	import pwfs_pkg::*;

	localparam int MarkRun      = 10;
	localparam int FrameLen     = 18 + 2 * MarkRun;
	localparam int SettleCycles = 4;
	localparam int TailCycles   = 8;
	localparam int StallLimit   = 400;
	localparam int MaxReports   = 10;

	localparam logic [CfgAddrW-1:0] REG_SPARE = 2'd3;

	typedef enum logic {
		ENT_ITEM,
		ENT_WRITE
	} entry_kind_t;

	typedef struct {
		entry_kind_t         kind;
		req_item_t           item;
		logic [CfgAddrW-1:0] addr;
		ticks_t              data;
	} pending_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	pwfs_req_if req_ch();
	pwfs_res_if res_ch();
	pwfs_cfg_if cfg_ch();

	pulse_width_frame_serializer_unit #(
		.MARK_RUN(MarkRun)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.res   (res_ch),
		.cfg   (cfg_ch)
	);

	always #10 clk = ~clk;

	pending_t  send_q[$];
	res_item_t line_status_q[$];

	timing_t               timing_sh;
	logic [FrameLen-1:0]   frame_bits;
	logic [5:0]            bits_left;
	logic                  high_phase;
	ticks_t                phase_left;
	logic                  line_busy;

	int items_sent;
	int results_seen;
	int errors = 0;
	int frames_taken = 0;
	int frames_refused = 0;
	int frames_done = 0;
	int idle_pct;
	int idle_left;
	int stall_left;
	int quiet_cycles = 0;

	pending_t  head;
	logic      next_req;
	logic      next_cfg;
	res_item_t got;
	res_item_t want;

	function automatic void start_pulse();
		ticks_t width;
		width = frame_bits[bits_left - 6'd1] ? timing_sh.long_pulse : timing_sh.short_pulse;
		high_phase = 1'b1;
		phase_left = (width == '0) ? ticks_t'(1) : width;
	endfunction

	function automatic res_item_t step_line(input req_item_t it);
		res_item_t r;
		r = '0;
		if (it.kind == KIND_REQUEST) begin
			if (!line_busy) begin
				frame_bits = {1'b1, {MarkRun{1'b0}}, 1'b1, it.mode_bits, it.param_code, 2'b10,
					it.data_byte, 1'b0, {MarkRun{1'b1}}, 1'b0};
				bits_left = 6'(FrameLen);
				line_busy = 1'b1;
				start_pulse();
				r.accepted = 1'b1;
				frames_taken++;
			end else begin
				frames_refused++;
			end
			r.pin_level = line_busy && high_phase;
		end else if (line_busy) begin
			r.pin_level = high_phase;
			if (phase_left != '0)
				phase_left--;
			if (phase_left == '0) begin
				if (high_phase) begin
					high_phase = 1'b0;
					phase_left = (timing_sh.gap == '0) ? ticks_t'(1) : timing_sh.gap;
				end else begin
					if (bits_left != '0)
						bits_left--;
					if (bits_left == '0) begin
						line_busy = 1'b0;
						high_phase = 1'b0;
						r.frame_done = 1'b1;
						frames_done++;
					end else begin
						start_pulse();
					end
				end
			end
		end
		r.busy_res = line_busy;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid      <= 1'b0;
			req_ch.kind       <= KIND_TICK;
			req_ch.mode_bits  <= '0;
			req_ch.param_code <= '0;
			req_ch.data_byte  <= '0;
			cfg_ch.valid      <= 1'b0;
			cfg_ch.addr       <= REG_LONG_PULSE;
			cfg_ch.data       <= '0;
			items_sent        <= 0;
			timing_sh  = {LONG_PULSE_RST, SHORT_PULSE_RST, GAP_RST};
			frame_bits = '0;
			bits_left  = '0;
			high_phase = 1'b0;
			phase_left = '0;
			line_busy  = 1'b0;
			idle_left  = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				line_status_q.push_back(step_line({req_ch.kind, req_ch.mode_bits,
					req_ch.param_code, req_ch.data_byte}));
				items_sent <= items_sent + 1;
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.addr)
					REG_LONG_PULSE:  timing_sh.long_pulse = cfg_ch.data;
					REG_SHORT_PULSE: timing_sh.short_pulse = cfg_ch.data;
					REG_GAP:         timing_sh.gap = cfg_ch.data;
					default: ;
				endcase
			end
			if (!(req_ch.valid && !req_ch.ready) && !(cfg_ch.valid && !cfg_ch.ready)) begin
				next_req = 1'b0;
				next_cfg = 1'b0;
				if (idle_left > 0) begin
					idle_left--;
				end else if (send_q.size() > 0) begin
					head = send_q.pop_front();
					if (head.kind == ENT_WRITE) begin
						next_cfg = 1'b1;
						cfg_ch.addr <= head.addr;
						cfg_ch.data <= head.data;
					end else begin
						next_req = 1'b1;
						req_ch.kind       <= head.item.kind;
						req_ch.mode_bits  <= head.item.mode_bits;
						req_ch.param_code <= head.item.param_code;
						req_ch.data_byte  <= head.item.data_byte;
					end
					if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
						idle_left = $urandom_range(1, 7);
				end
				req_ch.valid <= next_req;
				cfg_ch.valid <= next_cfg;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			results_seen <= 0;
			stall_left = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				got.pin_level  = res_ch.pin_level;
				got.busy_res   = res_ch.busy_res;
				got.accepted   = res_ch.accepted;
				got.frame_done = res_ch.frame_done;
				results_seen <= results_seen + 1;
				if (line_status_q.size() == 0) begin
					if (errors < MaxReports)
						$display("result %0d unexpected: pin %b busy %b acc %b done %b",
							results_seen, got.pin_level, got.busy_res, got.accepted,
							got.frame_done);
					errors++;
				end else begin
					want = line_status_q.pop_front();
					if (got.pin_level !== want.pin_level || got.busy_res !== want.busy_res ||
							got.accepted !== want.accepted ||
							got.frame_done !== want.frame_done) begin
						if (errors < MaxReports)
							$display("result %0d (pin busy acc done): expected %b%b%b%b, got %b%b%b%b",
								results_seen, want.pin_level, want.busy_res, want.accepted,
								want.frame_done, got.pin_level, got.busy_res, got.accepted,
								got.frame_done);
						errors++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
				if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
					stall_left = $urandom_range(1, 7);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= StallLimit) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic push_item(input logic kind, input logic [ModeW-1:0] mode,
			input logic [CodeW-1:0] code, input logic [DataW-1:0] data);
		pending_t e;
		e.kind = ENT_ITEM;
		e.item = {kind, mode, code, data};
		e.addr = '0;
		e.data = '0;
		send_q.push_back(e);
	endtask

	task automatic push_random_req();
		push_item(KIND_REQUEST, ModeW'($urandom_range(0, 3)), CodeW'($urandom_range(0, 3)),
			DataW'($urandom_range(0, 255)));
	endtask

	task automatic push_ticks(input int n);
		repeat (n)
			push_item(KIND_TICK, ModeW'($urandom_range(0, 3)), CodeW'($urandom_range(0, 3)),
				DataW'($urandom_range(0, 255)));
	endtask

	task automatic push_write(input logic [CfgAddrW-1:0] addr, input ticks_t data);
		pending_t e;
		e.kind = ENT_WRITE;
		e.item = '0;
		e.addr = addr;
		e.data = data;
		send_q.push_back(e);
	endtask

	task automatic wait_drained();
		while (send_q.size() != 0 || req_ch.valid || cfg_ch.valid || items_sent != results_seen)
			@(negedge clk);
	endtask

	task automatic set_timing(input ticks_t long_t, input ticks_t short_t, input ticks_t gap_t);
		wait_drained();
		repeat (SettleCycles) @(negedge clk);
		push_write(REG_LONG_PULSE, long_t);
		push_write(REG_SHORT_PULSE, short_t);
		push_write(REG_GAP, gap_t);
	endtask

	task automatic run_out_frame();
		wait_drained();
		while (line_busy) begin
			push_ticks(8);
			wait_drained();
		end
	endtask

	task automatic random_phase(input int n, input int req_pct);
		repeat (n) begin
			if ($urandom_range(0, 99) < req_pct)
				push_random_req();
			else
				push_ticks(1);
		end
	endtask

	initial begin
		idle_pct = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push_ticks(2);
		push_item(KIND_REQUEST, 2'd3, 2'd3, 8'hFF);
		push_item(KIND_REQUEST, 2'd0, 2'd0, 8'h00);
		push_ticks(20);
		set_timing(16'd2, 16'd0, 16'd0);
		push_write(REG_SPARE, 16'hFFFF);
		run_out_frame();
		push_item(KIND_REQUEST, 2'd1, 2'd2, 8'hA5);
		push_item(KIND_REQUEST, 2'd2, 2'd1, 8'h5A);
		run_out_frame();
		push_item(KIND_TICK, 2'd3, 2'd3, 8'hFF);

		for (int p = 0; p < 4; p++) begin
			idle_pct = (p == 3) ? 0 : $urandom_range(5, 25);
			run_out_frame();
			set_timing(ticks_t'($urandom_range(1, 4)), ticks_t'($urandom_range(0, 2)),
				ticks_t'($urandom_range(0, 2)));
			random_phase(80, (p % 3 == 0) ? 30 : $urandom_range(2, 8));
		end

		idle_pct = 10;
		run_out_frame();
		set_timing(16'd160, 16'd1, 16'd1);
		push_random_req();
		push_ticks(163);
		set_timing(16'd1, 16'd1, 16'd2);
		run_out_frame();
		set_timing(16'd1, 16'd1, 16'd160);
		push_random_req();
		push_ticks(163);
		set_timing(16'd2, 16'd1, 16'd1);
		run_out_frame();

		idle_pct = 0;
		set_timing(ticks_t'($urandom_range(1, 3)), ticks_t'($urandom_range(0, 2)),
			ticks_t'($urandom_range(0, 2)));
		random_phase(120, 8);
		wait_drained();
		repeat (TailCycles) @(negedge clk);

		if (line_status_q.size() != 0)
			$display("%0d expected results never arrived", line_status_q.size());
		$display("Checked %0d line results: %0d frames started, %0d finished, %0d refused.",
			results_seen, frames_taken, frames_done, frames_refused);
		$display("Timing settings ranged from zero ticks up to 160-tick pulses and gaps.");
		if (errors == 0 && line_status_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
